[src/range_max_min_difference_assert.svh]
// Assertion macros for the range query block.
`ifndef RANGE_MAX_MIN_DIFFERENCE_ASSERT_SVH
`define RANGE_MAX_MIN_DIFFERENCE_ASSERT_SVH

// A property checked at every clock edge outside of reset.
`define RMMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define RMMD_ASSERT_NEXT(lbl, trig, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) trig |=> post) else $error(msg);

`endif

[src/rmmd_pkg.sv]
package rmmd_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int TABLE_LEVELS_DEF = 11;

  localparam int CMD_W     = 2;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = 10;
  localparam int STAT_W    = 2;
  localparam int LEN_W     = IDX_W + 1;
  localparam int LVL_ONE_W = $clog2(LEN_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [VAL_W-1:0]        diff_t;
  typedef logic [IDX_W-1:0]        index_t;

  // Position of the leading one of a nonzero range length.
  function automatic logic [LVL_ONE_W-1:0] lead_one(input logic [LEN_W-1:0] x);
    logic [LVL_ONE_W-1:0] k;
    k = '0;
    for (int b = 1; b < LEN_W; b++) begin
      if (x[b]) begin
        k = LVL_ONE_W'(b);
      end
    end
    return k;
  endfunction

endpackage

[src/rmmd_in_if.sv]
interface rmmd_in_if;
  logic              valid;
  logic              ready;
  rmmd_pkg::cmd_t    cmd;
  rmmd_pkg::value_t  element_value;
  rmmd_pkg::index_t  left_index;
  rmmd_pkg::index_t  right_index;

  modport source (output valid, output cmd, output element_value,
                  output left_index, output right_index, input ready);
  modport sink (input valid, input cmd, input element_value,
                input left_index, input right_index, output ready);
endinterface

[src/rmmd_out_if.sv]
interface rmmd_out_if;
  logic                valid;
  logic                ready;
  rmmd_pkg::status_t   status;
  rmmd_pkg::value_t    range_max;
  rmmd_pkg::value_t    range_min;
  rmmd_pkg::diff_t     max_min_difference;

  modport source (output valid, output status, output range_max,
                  output range_min, output max_min_difference, input ready);
  modport sink (input valid, input status, input range_max,
                input range_min, input max_min_difference, output ready);
endinterface

[src/rmmd_mem.sv]
module rmmd_mem #(
  parameter int DEPTH = rmmd_pkg::MAX_ELEMENTS_DEF * rmmd_pkg::TABLE_LEVELS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  rmmd_pkg::value_t wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output rmmd_pkg::value_t rdata0,
  output rmmd_pkg::value_t rdata1
);

  rmmd_pkg::value_t mem_r [DEPTH];
  rmmd_pkg::value_t rdata0_r;
  rmmd_pkg::value_t rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata0_r <= mem_r[raddr0];
    rdata1_r <= mem_r[raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

[src/range_max_min_difference.sv]
// Channel   Port     Dir  Beat contents
// input     in_ch    in   cmd, element_value, left_index, right_index
// result    out_ch   out  status, range_max, range_min, max_min_difference
//
// Append, clear and unused commands pass their result through the result and output registers.
// A query on built tables goes through table read, compare, subtract and output load;
// a bad range skips compare and subtract. A query after appends first rebuilds the
// tables level by level, with a check and a write step for each entry of a level.
// Reset clears the element count and marks the tables built; memories keep contents.
// A waiting result does not block the next beat; a second one holds off the input.
`include "range_max_min_difference_assert.svh"

module range_max_min_difference #(
  parameter int MAX_ELEMENTS = rmmd_pkg::MAX_ELEMENTS_DEF,
  parameter int TABLE_LEVELS = rmmd_pkg::TABLE_LEVELS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  rmmd_in_if.sink    in_ch,
  rmmd_out_if.source out_ch
);

  localparam int CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int SW    = CW + 1;
  localparam int DEPTH = MAX_ELEMENTS * TABLE_LEVELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(TABLE_LEVELS + 1);
  localparam int KW    = rmmd_pkg::LVL_ONE_W;
  localparam int LNW   = rmmd_pkg::LEN_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BCHK,
    S_BWR,
    S_QRD,
    S_QCMP,
    S_QDIF,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               current_r, current_nxt;
  rmmd_pkg::index_t   left_r, left_nxt;
  rmmd_pkg::index_t   right_r, right_nxt;
  logic [LW-1:0]      lvl_r, lvl_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [AW-1:0]      prev_r, prev_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  rmmd_pkg::value_t   mn_r, mn_nxt;
  rmmd_pkg::value_t   mx_r, mx_nxt;
  rmmd_pkg::status_t  res_status_r, res_status_nxt;
  rmmd_pkg::value_t   res_max_r, res_max_nxt;
  rmmd_pkg::value_t   res_min_r, res_min_nxt;
  rmmd_pkg::diff_t    res_diff_r, res_diff_nxt;
  logic               out_valid_r, out_valid_nxt;
  rmmd_pkg::status_t  out_status_r, out_status_nxt;
  rmmd_pkg::value_t   out_max_r, out_max_nxt;
  rmmd_pkg::value_t   out_min_r, out_min_nxt;
  rmmd_pkg::diff_t    out_diff_r, out_diff_nxt;

  logic               in_fire;
  logic               store_full;
  logic               we;
  logic [AW-1:0]      waddr;
  rmmd_pkg::value_t   wdata_min, wdata_max;
  logic [AW-1:0]      raddr0, raddr1;
  rmmd_pkg::value_t   rd_min0, rd_min1, rd_max0, rd_max1;
  rmmd_pkg::value_t   cmp_min, cmp_max;
  logic               lvl_done, row_done;
  logic [SW-1:0]      span, half;
  logic               q_bad;
  logic [LNW-1:0]     q_len, q_span, q_j;
  logic [KW-1:0]      q_k_raw, q_k;
  logic [AW-1:0]      q_base;
  logic               diff_ok;
  logic               err_clean;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign store_full  = (count_r >= CW'(MAX_ELEMENTS));

  // The one compare unit serves both the table build and the query answer.
  assign cmp_min = (rd_min0 < rd_min1) ? rd_min0 : rd_min1;
  assign cmp_max = (rd_max0 > rd_max1) ? rd_max0 : rd_max1;

  assign lvl_done = (lvl_r >= LW'(TABLE_LEVELS)) || ((count_r >> lvl_r) == '0);
  assign span     = SW'(1) << lvl_r;
  assign half     = span >> 1;
  assign row_done = ((SW'(i_r) + span) > SW'(count_r));

  assign q_bad   = (left_r > right_r) || (32'(right_r) >= 32'(count_r));
  assign q_len   = LNW'(right_r) - LNW'(left_r) + LNW'(1);
  assign q_k_raw = rmmd_pkg::lead_one(q_len);
  assign q_k     = (32'(q_k_raw) > TABLE_LEVELS - 1) ? KW'(TABLE_LEVELS - 1) : q_k_raw;
  assign q_span  = LNW'(1) << q_k;
  assign q_j     = LNW'(right_r) + LNW'(1) - q_span;
  assign q_base  = AW'(32'(q_k) * MAX_ELEMENTS);

  always_comb begin
    if (state_r == S_QRD) begin
      raddr0 = q_base + AW'(left_r);
      raddr1 = q_base + AW'(q_j);
    end else begin
      raddr0 = prev_r + AW'(i_r);
      raddr1 = prev_r + AW'(i_r) + AW'(half);
    end
  end

  always_comb begin
    if (state_r == S_BWR) begin
      we        = 1'b1;
      waddr     = base_r + AW'(i_r);
      wdata_min = cmp_min;
      wdata_max = cmp_max;
    end else begin
      we        = in_fire && (in_ch.cmd == rmmd_pkg::CMD_APPEND) && !store_full;
      waddr     = AW'(count_r);
      wdata_min = in_ch.element_value;
      wdata_max = in_ch.element_value;
    end
  end

  rmmd_mem #(.DEPTH(DEPTH), .AW(AW)) u_min_mem (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata_min),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rd_min0),
    .rdata1 (rd_min1)
  );

  rmmd_mem #(.DEPTH(DEPTH), .AW(AW)) u_max_mem (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata_max),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rd_max0),
    .rdata1 (rd_max1)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    current_nxt    = current_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    lvl_nxt        = lvl_r;
    i_nxt          = i_r;
    prev_nxt       = prev_r;
    base_nxt       = base_r;
    mn_nxt         = mn_r;
    mx_nxt         = mx_r;
    res_status_nxt = res_status_r;
    res_max_nxt    = res_max_r;
    res_min_nxt    = res_min_r;
    res_diff_nxt   = res_diff_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_max_nxt    = out_max_r;
    out_min_nxt    = out_min_r;
    out_diff_nxt   = out_diff_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_status_nxt = rmmd_pkg::ST_OK;
          res_max_nxt    = '0;
          res_min_nxt    = '0;
          res_diff_nxt   = '0;
          state_nxt      = S_EMIT;
          unique case (in_ch.cmd)
            rmmd_pkg::CMD_APPEND: begin
              if (store_full) begin
                res_status_nxt = rmmd_pkg::ST_FULL;
              end else begin
                count_nxt   = count_r + CW'(1);
                current_nxt = 1'b0;
              end
            end
            rmmd_pkg::CMD_QUERY: begin
              left_nxt  = in_ch.left_index;
              right_nxt = in_ch.right_index;
              if (current_r) begin
                state_nxt = S_QRD;
              end else begin
                lvl_nxt   = LW'(1);
                i_nxt     = '0;
                prev_nxt  = '0;
                base_nxt  = AW'(MAX_ELEMENTS);
                state_nxt = S_BCHK;
              end
            end
            rmmd_pkg::CMD_CLEAR: begin
              count_nxt   = '0;
              current_nxt = 1'b1;
            end
            rmmd_pkg::CMD_NOP: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_BCHK: begin
        if (lvl_done) begin
          current_nxt = 1'b1;
          state_nxt   = S_QRD;
        end else if (row_done) begin
          lvl_nxt  = lvl_r + LW'(1);
          prev_nxt = base_r;
          base_nxt = base_r + AW'(MAX_ELEMENTS);
          i_nxt    = '0;
        end else begin
          state_nxt = S_BWR;
        end
      end
      S_BWR: begin
        i_nxt     = i_r + CW'(1);
        state_nxt = S_BCHK;
      end
      S_QRD: begin
        if (q_bad) begin
          res_status_nxt = rmmd_pkg::ST_BAD_RANGE;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_QCMP;
        end
      end
      S_QCMP: begin
        mn_nxt    = cmp_min;
        mx_nxt    = cmp_max;
        state_nxt = S_QDIF;
      end
      S_QDIF: begin
        res_status_nxt = rmmd_pkg::ST_OK;
        res_max_nxt    = mx_r;
        res_min_nxt    = mn_r;
        res_diff_nxt   = rmmd_pkg::diff_t'(mx_r) - rmmd_pkg::diff_t'(mn_r);
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_max_nxt    = res_max_r;
          out_min_nxt    = res_min_r;
          out_diff_nxt   = res_diff_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      current_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      current_r   <= current_nxt;
      out_valid_r <= out_valid_nxt;
    end
    left_r       <= left_nxt;
    right_r      <= right_nxt;
    lvl_r        <= lvl_nxt;
    i_r          <= i_nxt;
    prev_r       <= prev_nxt;
    base_r       <= base_nxt;
    mn_r         <= mn_nxt;
    mx_r         <= mx_nxt;
    res_status_r <= res_status_nxt;
    res_max_r    <= res_max_nxt;
    res_min_r    <= res_min_nxt;
    res_diff_r   <= res_diff_nxt;
    out_status_r <= out_status_nxt;
    out_max_r    <= out_max_nxt;
    out_min_r    <= out_min_nxt;
    out_diff_r   <= out_diff_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = out_status_r;
  assign out_ch.range_max          = out_max_r;
  assign out_ch.range_min          = out_min_r;
  assign out_ch.max_min_difference = out_diff_r;

  assign diff_ok   = (out_diff_r == (rmmd_pkg::diff_t'(out_max_r) - rmmd_pkg::diff_t'(out_min_r)));
  assign err_clean = (out_status_r == rmmd_pkg::ST_OK) || ((out_max_r == '0) && (out_min_r == '0));

  `RMMD_ASSERT(a_count_bound, 32'(count_r) <= MAX_ELEMENTS, "element count beyond store size")
  `RMMD_ASSERT(a_query_built, (state_r == S_QRD) |-> current_r, "query read on stale tables")
  `RMMD_ASSERT(a_diff_match, out_valid_r |-> diff_ok, "difference does not match max and min")
  `RMMD_ASSERT(a_err_zero, out_valid_r |-> err_clean, "error result carries data")
  `RMMD_ASSERT_NEXT(a_busy_after_beat, in_fire, !in_ch.ready, "ready right after a taken beat")

endmodule
